/* design/ptpd_pkg.sv */
// ----------------------------------------------------------------------------
// Point-to-plane distance package
// Shared widths and types for the point-to-plane distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpd_pkg;

  // Coordinate format; the distance keeps the fraction bits of the inputs.
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DistWidth  = 32;

  // Edge vectors and offsets from the first plane point.
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  // One cross-product term.
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  // Normal component, signed.
  localparam int unsigned NormWidth  = ProdWidth + 1;
  // Limb width used to split wide operands into narrow multiplies.
  localparam int unsigned LimbWidth  = 34;
  // Normal magnitude held in two limbs.
  localparam int unsigned MagWidth   = 2 * LimbWidth;
  // Squared normal length.
  localparam int unsigned Len2Width  = 4 * LimbWidth;
  // Plane value at the query point, signed.
  localparam int unsigned NumWidth   = 3 * LimbWidth;
  // Squared plane value and the running remainder of the root search.
  localparam int unsigned SqWidth    = 6 * LimbWidth;
  // Quotient bits; the top bit marks an out-of-range distance.
  localparam int unsigned QBits      = DistWidth + 1;

  // Partial product widths of the plane value.
  localparam int unsigned HiPartWidth = NormWidth - LimbWidth + DiffWidth;
  localparam int unsigned LoPartWidth = LimbWidth + 1 + DiffWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [NormWidth-1:0]  norm_t;
  typedef logic        [MagWidth-1:0]   mag_t;
  typedef logic        [MagWidth-1:0]   limb_sq_t;
  typedef logic        [Len2Width-1:0]  len2_t;
  typedef logic signed [NumWidth-1:0]   num_t;
  typedef logic        [NumWidth-1:0]   num_mag_t;
  typedef logic        [SqWidth-1:0]    sq_t;
  typedef logic        [QBits-1:0]      quot_t;

endpackage

`default_nettype wire

/* design/point_to_plane_distance.sv */
// ----------------------------------------------------------------------------
// Point-to-plane distance
// Distance from a query point to the plane through three points, exact
// fixed point, rounded down, with degenerate-plane and saturation flags.
// ----------------------------------------------------------------------------
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  in       | in_valid_i, in_ready_o, 12 coords | sink
//  out      | out_valid_o, out_ready_i, results | source
//
// A word enters every cycle unless stalled. It passes 9 arithmetic stages
// (differences, cross product, normal, split multiplies, sums, magnitude,
// squares) then 33 root stages, one quotient bit each, then the output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stall holds every stage in place.
// Reset clears only the valid bits.
`default_nettype none

module point_to_plane_distance (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire ptpd_pkg::coord_t         query_x_i,
  input  wire ptpd_pkg::coord_t         query_y_i,
  input  wire ptpd_pkg::coord_t         query_z_i,
  input  wire ptpd_pkg::coord_t         first_x_i,
  input  wire ptpd_pkg::coord_t         first_y_i,
  input  wire ptpd_pkg::coord_t         first_z_i,
  input  wire ptpd_pkg::coord_t         second_x_i,
  input  wire ptpd_pkg::coord_t         second_y_i,
  input  wire ptpd_pkg::coord_t         second_z_i,
  input  wire ptpd_pkg::coord_t         third_x_i,
  input  wire ptpd_pkg::coord_t         third_y_i,
  input  wire ptpd_pkg::coord_t         third_z_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [ptpd_pkg::DistWidth-1:0] distance_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);
  import ptpd_pkg::*;

  // Global advance: everything moves when the output register can move.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Valid bits of the arithmetic stages.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q;
  logic rt_v_q [QBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      rt_v_q[0]   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      rt_v_q[0]   <= s8_v_q;
      out_valid_q <= rt_v_q[QBits];
    end
  end

  // Stage 1: edge vectors and query offset from the first point.
  diff_t s1_ux_q, s1_uy_q, s1_uz_q, s1_vx_q, s1_vy_q, s1_vz_q;
  diff_t s1_dx_q, s1_dy_q, s1_dz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ux_q <= DiffWidth'(second_x_i) - DiffWidth'(first_x_i);
      s1_uy_q <= DiffWidth'(second_y_i) - DiffWidth'(first_y_i);
      s1_uz_q <= DiffWidth'(second_z_i) - DiffWidth'(first_z_i);
      s1_vx_q <= DiffWidth'(third_x_i) - DiffWidth'(first_x_i);
      s1_vy_q <= DiffWidth'(third_y_i) - DiffWidth'(first_y_i);
      s1_vz_q <= DiffWidth'(third_z_i) - DiffWidth'(first_z_i);
      s1_dx_q <= DiffWidth'(query_x_i) - DiffWidth'(first_x_i);
      s1_dy_q <= DiffWidth'(query_y_i) - DiffWidth'(first_y_i);
      s1_dz_q <= DiffWidth'(query_z_i) - DiffWidth'(first_z_i);
    end
  end

  // Stage 2: the six cross-product terms.
  prod_t s2_p_q [6];
  diff_t s2_dx_q, s2_dy_q, s2_dz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_p_q[0] <= ProdWidth'(s1_uy_q) * ProdWidth'(s1_vz_q);
      s2_p_q[1] <= ProdWidth'(s1_uz_q) * ProdWidth'(s1_vy_q);
      s2_p_q[2] <= ProdWidth'(s1_uz_q) * ProdWidth'(s1_vx_q);
      s2_p_q[3] <= ProdWidth'(s1_ux_q) * ProdWidth'(s1_vz_q);
      s2_p_q[4] <= ProdWidth'(s1_ux_q) * ProdWidth'(s1_vy_q);
      s2_p_q[5] <= ProdWidth'(s1_uy_q) * ProdWidth'(s1_vx_q);
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_dz_q   <= s1_dz_q;
    end
  end

  // Stage 3: normal components, signed and as magnitudes.
  norm_t s3_n_q   [3];
  mag_t  s3_mag_q [3];
  diff_t s3_d_q   [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_n_q[i] <= NormWidth'(s2_p_q[2*i]) - NormWidth'(s2_p_q[2*i+1]);
        if (s2_p_q[2*i] >= s2_p_q[2*i+1]) begin
          s3_mag_q[i] <= MagWidth'(NormWidth'(s2_p_q[2*i]) - NormWidth'(s2_p_q[2*i+1]));
        end else begin
          s3_mag_q[i] <= MagWidth'(NormWidth'(s2_p_q[2*i+1]) - NormWidth'(s2_p_q[2*i]));
        end
      end
      s3_d_q[0] <= s2_dx_q;
      s3_d_q[1] <= s2_dy_q;
      s3_d_q[2] <= s2_dz_q;
    end
  end

  // Stage 4: limb products for the squared length and the plane value.
  limb_sq_t                       s4_hh_q [3];
  limb_sq_t                       s4_hl_q [3];
  limb_sq_t                       s4_ll_q [3];
  logic signed [HiPartWidth-1:0]  s4_nh_q [3];
  logic signed [LoPartWidth-1:0]  s4_nl_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_hh_q[i] <= MagWidth'(s3_mag_q[i][MagWidth-1:LimbWidth])
                    * MagWidth'(s3_mag_q[i][MagWidth-1:LimbWidth]);
        s4_hl_q[i] <= MagWidth'(s3_mag_q[i][MagWidth-1:LimbWidth])
                    * MagWidth'(s3_mag_q[i][LimbWidth-1:0]);
        s4_ll_q[i] <= MagWidth'(s3_mag_q[i][LimbWidth-1:0])
                    * MagWidth'(s3_mag_q[i][LimbWidth-1:0]);
        s4_nh_q[i] <= HiPartWidth'($signed(s3_n_q[i][NormWidth-1:LimbWidth]))
                    * HiPartWidth'(s3_d_q[i]);
        s4_nl_q[i] <= LoPartWidth'($signed({1'b0, s3_n_q[i][LimbWidth-1:0]}))
                    * LoPartWidth'(s3_d_q[i]);
      end
    end
  end

  // Stage 5: recombine the limbs of each square and each product.
  len2_t s5_sq_q [3];
  num_t  s5_np_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq_q[i] <= (Len2Width'(s4_hh_q[i]) << (2 * LimbWidth))
                    + (Len2Width'(s4_hl_q[i]) << (LimbWidth + 1))
                    + Len2Width'(s4_ll_q[i]);
        s5_np_q[i] <= (NumWidth'(s4_nh_q[i]) <<< LimbWidth) + NumWidth'(s4_nl_q[i]);
      end
    end
  end

  // Stage 6: squared normal length and plane value.
  len2_t s6_len2_q;
  num_t  s6_num_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_len2_q <= s5_sq_q[0] + s5_sq_q[1] + s5_sq_q[2];
      s6_num_q  <= s5_np_q[0] + s5_np_q[1] + s5_np_q[2];
    end
  end

  // Stage 7: magnitude of the plane value and the zero-normal test.
  len2_t    s7_len2_q;
  num_mag_t s7_mag_q;
  logic     s7_deg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_len2_q <= s6_len2_q;
      s7_deg_q  <= (s6_len2_q == '0);
      s7_mag_q  <= s6_num_q[NumWidth-1] ? num_mag_t'(-s6_num_q) : num_mag_t'(s6_num_q);
    end
  end

  // Stage 8: limb products of the squared plane value.
  len2_t    s8_len2_q;
  logic     s8_deg_q;
  limb_sq_t s8_p00_q, s8_p11_q, s8_p22_q, s8_p01_q, s8_p02_q, s8_p12_q;
  logic [LimbWidth-1:0] n0, n1, n2;

  assign n0 = s7_mag_q[LimbWidth-1:0];
  assign n1 = s7_mag_q[2*LimbWidth-1:LimbWidth];
  assign n2 = s7_mag_q[3*LimbWidth-1:2*LimbWidth];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_len2_q <= s7_len2_q;
      s8_deg_q  <= s7_deg_q;
      s8_p00_q  <= MagWidth'(n0) * MagWidth'(n0);
      s8_p11_q  <= MagWidth'(n1) * MagWidth'(n1);
      s8_p22_q  <= MagWidth'(n2) * MagWidth'(n2);
      s8_p01_q  <= MagWidth'(n0) * MagWidth'(n1);
      s8_p02_q  <= MagWidth'(n0) * MagWidth'(n2);
      s8_p12_q  <= MagWidth'(n1) * MagWidth'(n2);
    end
  end

  // Root stages: stage k settles one quotient bit, top bit first. Each keeps
  // the remainder N*N - q*q*L and the product q*L, so no multiply is needed.
  sq_t   rt_rem_q [QBits+1];
  sq_t   rt_t_q   [QBits+1];
  sq_t   rt_len_q [QBits+1];
  quot_t rt_q_q   [QBits+1];
  logic  rt_deg_q [QBits+1];

  // Entry stage: squared plane value and a zero quotient.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_rem_q[0] <= (SqWidth'(s8_p22_q) << (4 * LimbWidth))
                   + (SqWidth'(s8_p12_q) << (3 * LimbWidth + 1))
                   + (SqWidth'(s8_p02_q) << (2 * LimbWidth + 1))
                   + (SqWidth'(s8_p11_q) << (2 * LimbWidth))
                   + (SqWidth'(s8_p01_q) << (LimbWidth + 1))
                   + SqWidth'(s8_p00_q);
      rt_t_q[0]   <= '0;
      rt_len_q[0] <= SqWidth'(s8_len2_q);
      rt_q_q[0]   <= '0;
      rt_deg_q[0] <= s8_deg_q;
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_root
    localparam int unsigned Bit = QBits - 1 - k;
    sq_t  step;
    logic take;

    // Growth of q*q*L when this bit is set.
    assign step = (rt_t_q[k] << (Bit + 1)) + (rt_len_q[k] << (2 * Bit));
    assign take = (step <= rt_rem_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        rt_v_q[k+1] <= rt_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_len_q[k+1] <= rt_len_q[k];
        rt_deg_q[k+1] <= rt_deg_q[k];
        if (take) begin
          rt_rem_q[k+1] <= rt_rem_q[k] - step;
          rt_t_q[k+1]   <= rt_t_q[k] + (rt_len_q[k] << Bit);
          rt_q_q[k+1]   <= rt_q_q[k] | (QBits'(1) << Bit);
        end else begin
          rt_rem_q[k+1] <= rt_rem_q[k];
          rt_t_q[k+1]   <= rt_t_q[k];
          rt_q_q[k+1]   <= rt_q_q[k];
        end
      end
    end
  end

  // Output register: clamp, flag and hold the word until it is taken.
  logic [DistWidth-1:0] dist_q;
  logic                 deg_q;
  logic                 sat_q;
  logic                 over;

  assign over = rt_q_q[QBits][QBits-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deg_q <= rt_deg_q[QBits];
      sat_q <= !rt_deg_q[QBits] && over;
      if (rt_deg_q[QBits]) begin
        dist_q <= '0;
      end else if (over) begin
        dist_q <= '1;
      end else begin
        dist_q <= rt_q_q[QBits][DistWidth-1:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_o   = dist_q;
  assign degenerate_o = deg_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

/* sim/point_to_plane_distance_tb.sv */
// ----------------------------------------------------------------------------
// Point-to-plane distance testbench
// Drives plane and query words through the valid/ready input channel with
// random gaps, stalls the result channel at random, and checks every result
// against an exact wide-integer computation of the truncated distance and
// its degenerate and saturation flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_to_plane_distance_tb;

  import ptpd_pkg::*;

  // Index of each coordinate within one input word.
  localparam int QX = 0, QY = 1, QZ = 2, AX = 3, AY = 4, AZ = 5;
  localparam int BX = 6, BY = 7, BZ = 8, CX = 9, CY = 10, CZ = 11;
  localparam int NumCoords  = 12;
  localparam int RandWords  = 800;
  localparam int PauseWord  = 400;
  localparam int DrainWait  = 60;
  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 37;
  localparam coord_t CMax   = 32'sh7FFF_FFFF;
  localparam coord_t CMin   = 32'sh8000_0000;

  typedef logic signed [255:0] wide_t;
  typedef coord_t [NumCoords-1:0] coord_set_t;

  typedef struct packed {
    logic [DistWidth-1:0] distance;
    logic                 degenerate;
    logic                 saturated;
  } dist_result_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i;
  logic [DistWidth-1:0] distance_o;
  logic degenerate_o;
  logic saturated_o;
  coord_set_t word_q;

  coord_set_t   pending_words[$];
  dist_result_t expected_dists[$];
  // Counters start at zero before any process runs, so the first clock edge
  // at time zero cannot see them undefined.
  int sent_words = 0;
  int mismatches = 0;
  int cycles = 0;

  point_to_plane_distance uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .query_x_i   (word_q[QX]),
    .query_y_i   (word_q[QY]),
    .query_z_i   (word_q[QZ]),
    .first_x_i   (word_q[AX]),
    .first_y_i   (word_q[AY]),
    .first_z_i   (word_q[AZ]),
    .second_x_i  (word_q[BX]),
    .second_y_i  (word_q[BY]),
    .second_z_i  (word_q[BZ]),
    .third_x_i   (word_q[CX]),
    .third_y_i   (word_q[CY]),
    .third_z_i   (word_q[CZ]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o),
    .degenerate_o(degenerate_o),
    .saturated_o (saturated_o)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Exact distance: largest q with q*q*|n|^2 <= N*N, clamped to the output range.
  function automatic dist_result_t plane_distance(input coord_set_t w);
    wide_t c[NumCoords];
    wide_t ux, uy, uz, vx, vy, vz, na, nb, nc, len2, num, num2, cand, prod;
    logic [QBits-1:0] q;
    dist_result_t r;
    for (int i = 0; i < NumCoords; i++) begin
      c[i] = $signed(w[i]);
    end
    ux = c[BX] - c[AX];
    uy = c[BY] - c[AY];
    uz = c[BZ] - c[AZ];
    vx = c[CX] - c[AX];
    vy = c[CY] - c[AY];
    vz = c[CZ] - c[AZ];
    na = uy * vz - uz * vy;
    nb = uz * vx - ux * vz;
    nc = ux * vy - uy * vx;
    len2 = na * na + nb * nb + nc * nc;
    r = '0;
    if (len2 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    num = na * (c[QX] - c[AX]) + nb * (c[QY] - c[AY]) + nc * (c[QZ] - c[AZ]);
    if (num < 0) num = -num;
    num2 = num * num;
    q = '0;
    for (int b = QBits - 1; b >= 0; b--) begin
      cand = 0;
      cand[QBits-1:0] = q | (QBits'(1) << b);
      prod = cand * cand * len2;
      if ($unsigned(prod) <= $unsigned(num2)) q = cand[QBits-1:0];
    end
    if (q[QBits-1]) begin
      r.distance  = '1;
      r.saturated = 1'b1;
    end else begin
      r.distance = q[DistWidth-1:0];
    end
    return r;
  endfunction

  function automatic coord_set_t make_word(input coord_t q0, q1, q2, a0, a1, a2,
                                           b0, b1, b2, c0, c1, c2);
    coord_set_t w;
    w[QX] = q0; w[QY] = q1; w[QZ] = q2;
    w[AX] = a0; w[AY] = a1; w[AZ] = a2;
    w[BX] = b0; w[BY] = b1; w[BZ] = b2;
    w[CX] = c0; w[CY] = c1; w[CZ] = c2;
    return w;
  endfunction

  // One random coordinate: full range, small values, or near the extremes.
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return coord_t'($urandom());
    if (pick < 8) return coord_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    if (pick == 8) return CMax - coord_t'($urandom_range(0, 3));
    return CMin + coord_t'($urandom_range(0, 3));
  endfunction

  // Random word; some planes are made degenerate by repeating or lining up points.
  function automatic coord_set_t rand_word();
    coord_set_t w;
    int unsigned k;
    for (int i = 0; i < NumCoords; i++) begin
      w[i] = rand_coord();
    end
    case ($urandom_range(0, 15))
      0: begin
        w[CX] = w[AX]; w[CY] = w[AY]; w[CZ] = w[AZ];
      end
      1: begin
        w[BX] = w[CX]; w[BY] = w[CY]; w[BZ] = w[CZ];
      end
      2: begin
        // Third point on the line through the first two, when it fits.
        k = $urandom_range(0, 1);
        w[AX] = coord_t'($urandom_range(0, 255)) - 128;
        w[AY] = coord_t'($urandom_range(0, 255)) - 128;
        w[AZ] = coord_t'($urandom_range(0, 255)) - 128;
        w[BX] = w[AX] + 5; w[BY] = w[AY] - 3; w[BZ] = w[AZ] + 7;
        w[CX] = w[AX] + (k ? -10 : 15);
        w[CY] = w[AY] - (k ? -6 : 9);
        w[CZ] = w[AZ] + (k ? -14 : 21);
      end
      default: ;
    endcase
    return w;
  endfunction

  // Directed words, then random words.
  initial begin
    // All at the extremes.
    pending_words.push_back({NumCoords{CMax}});
    pending_words.push_back({NumCoords{CMin}});
    pending_words.push_back(make_word(CMax, CMin, CMax, CMin, CMax, CMin,
                                      CMax, CMax, CMin, CMin, CMin, CMax));
    pending_words.push_back(make_word(CMin, CMax, CMin, CMax, CMin, CMax,
                                      CMin, CMin, CMax, CMax, CMax, CMin));
    pending_words.push_back(make_word(CMax, CMax, CMax, CMin, CMin, CMin,
                                      CMax, CMin, CMin, CMin, CMax, CMin));
    pending_words.push_back(make_word(CMin, CMin, CMin, CMax, CMax, CMax,
                                      CMin, CMax, CMax, CMax, CMin, CMax));
    // Coincident plane points.
    pending_words.push_back(make_word(5, 6, 7, 9, 9, 9, 9, 9, 9, 9, 9, 9));
    pending_words.push_back(make_word(CMax, CMin, 0, CMin, CMin, CMin,
                                      CMin, CMin, CMin, CMin, CMin, CMin));
    // Collinear plane points.
    pending_words.push_back(make_word(1, 2, 3, 0, 0, 0, 65536, 65536, 65536,
                                      131072, 131072, 131072));
    pending_words.push_back(make_word(0, 0, 0, CMin, CMin, CMin, 0, 0, 0,
                                      CMax, CMax, CMax));
    // Query on the plane.
    pending_words.push_back(make_word(77, -99, 0, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    // Unit steps in z, one above the plane, and the largest value that still fits.
    pending_words.push_back(make_word(0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    pending_words.push_back(make_word(0, 0, CMax, 0, 0, CMin, 1, 0, CMin, 0, 1, CMin));
    pending_words.push_back(make_word(0, 0, CMin, 0, 0, CMax, 1, 0, CMax, 0, 1, CMax));
    // Distance above the output range: diagonal normal across the full cube.
    pending_words.push_back(make_word(CMax, CMax, CMax, CMin + 1, CMin + 1, CMin + 1,
                                      CMin + 2, CMin, CMin + 1, CMin + 2, CMin + 1, CMin));
    pending_words.push_back(make_word(CMin, CMin, CMin, CMax - 1, CMax - 1, CMax - 1,
                                      CMax - 2, CMax, CMax - 1, CMax - 2, CMax - 1, CMax));
    // Fractional distance that truncates.
    pending_words.push_back(make_word(1, 1, 1, 0, 0, 0, 1, -1, 0, 1, 0, -1));
    pending_words.push_back(make_word(-3, 0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 65536));
    for (int i = 0; i < RandWords; i++) begin
      pending_words.push_back(rand_word());
    end
  end

  // Reset and end of run.
  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_dists.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && expected_dists.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    word_q      = '0;
  end

  // Input driver: a new word at the falling edge once the last one was taken.
  logic word_taken;
  always @(posedge clk_i) begin
    word_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_dists.push_back(plane_distance(word_q));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (in_valid_i) sent_words <= sent_words + 1;
      // Hold off once until the pipeline has drained.
      if (sent_words + (in_valid_i ? 1 : 0) == PauseWord && expected_dists.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0 &&
          ((sent_words > 100 && sent_words < 250) || $urandom_range(0, 99) >= IdlePct)) begin
        word_q     <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stalls at random, with a stretch of steady acceptance.
  always @(negedge clk_i) begin
    out_ready_i <= (cycles > 1500 && cycles < 2000) || $urandom_range(0, 99) >= IdlePct;
  end

  // Result checker.
  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_dists.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = expected_dists.pop_front();
        if (distance_o !== want.distance || degenerate_o !== want.degenerate ||
            saturated_o !== want.saturated) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch at cycle %0d: expected dist %h degen %b sat %b, got %h %b %b",
                     cycles, want.distance, want.degenerate, want.saturated,
                     distance_o, degenerate_o, saturated_o);
          end
        end
      end
    end
  end

endmodule
